/* rtl/sspt_pkg.sv */
`default_nettype none
package sspt_pkg;
  localparam int SourceSlots = 6;
  localparam int SlotW = $clog2(SourceSlots);
  localparam int CountW = $clog2(SourceSlots + 1);

  typedef enum logic [2:0] {
    V_PREVIEW   = 3'd0,
    V_BAD_PRIO  = 3'd1,
    V_START     = 3'd2,
    V_UNTRACKED = 3'd3,
    V_OLD_SEQ   = 3'd4,
    V_ACCEPTED  = 3'd5,
    V_REMERGE   = 3'd6
  } verdict_t;

  typedef enum logic [1:0] {
    M_CLEAR = 2'd0,
    M_COPY  = 2'd1,
    M_HTP   = 2'd2
  } merge_t;

  typedef enum logic [1:0] {
    REG_PREVIEW = 2'd0,
    REG_MAXPRIO = 2'd1,
    REG_EXPIRY  = 2'd2,
    REG_STALE   = 2'd3
  } reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  function automatic logic [CountW-1:0] popcount(input logic [SourceSlots-1:0] v);
    logic [CountW-1:0] n;
    n = '0;
    for (int i = 0; i < SourceSlots; i++) n = n + CountW'(v[i]);
    return n;
  endfunction
endpackage
`default_nettype wire

/* rtl/sspt_ctrl.sv */
`default_nettype none
module sspt_ctrl (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire  logic out_stall,
  output sspt_pkg::cmd_t cmd
);
  import sspt_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        cmd.exec = 1'b1;
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/sspt_datapath.sv */
`default_nettype none
module sspt_datapath (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  sspt_pkg::cmd_t cmd,
  input  wire  logic        cfg_we,
  input  wire  logic [1:0]  cfg_index,
  input  wire  logic [15:0] cfg_data,
  input  wire  logic [63:0] source_id_high,
  input  wire  logic [63:0] source_id_low,
  input  wire  logic [7:0]  sequence_number,
  input  wire  logic [7:0]  packet_priority,
  input  wire  logic        preview_flag,
  input  wire  logic        terminate_flag,
  input  wire  logic [7:0]  slot_start_code,
  input  wire  logic [31:0] time_now_ms,
  output logic [2:0] verdict,
  output logic       write_enable,
  output logic [2:0] write_index,
  output logic [1:0] merge_mode,
  output logic [2:0] tracked_count,
  output logic [7:0] current_priority,
  output logic [5:0] valid_slots
);
  import sspt_pkg::*;

  logic              ign_prev;
  logic [7:0]        max_prio;
  logic [15:0]       expiry;
  logic signed [7:0] stale_lim;

  logic [63:0] p_idh, p_idl;
  logic [7:0]  p_seq, p_prio, p_sc;
  logic        p_prev, p_term;
  logic [31:0] p_now;

  logic [SourceSlots-1:0] vld;
  logic [63:0] id_h [SourceSlots];
  logic [63:0] id_l [SourceSlots];
  logic [7:0]  sq   [SourceSlots];
  logic [31:0] heard[SourceSlots];
  logic [7:0]  level;

  always_ff @(posedge clk) begin
    if (rst) begin
      ign_prev <= 1'b1;
      max_prio <= 8'd200;
      expiry <= 16'd2500;
      stale_lim <= -8'sd20;
    end else if (cfg_we) begin
      unique case (reg_t'(cfg_index))
        REG_PREVIEW: ign_prev <= cfg_data[0];
        REG_MAXPRIO: max_prio <= cfg_data[7:0];
        REG_EXPIRY:  expiry <= cfg_data;
        REG_STALE:   stale_lim <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_idh <= source_id_high; p_idl <= source_id_low;
      p_seq <= sequence_number; p_prio <= packet_priority;
      p_prev <= preview_flag; p_term <= terminate_flag;
      p_sc <= slot_start_code; p_now <= time_now_ms;
    end
  end

  verdict_t v_n;
  logic we_n, rm_n;
  logic [SlotW-1:0] widx_n;
  logic [SourceSlots-1:0] vld_n, keep;
  logic [7:0] lvl_n;
  logic hit_any, free_any, wr_new, wr_hit;
  logic [SlotW-1:0] hit, free;
  logic [31:0] age;
  logic signed [7:0] d;
  logic [CountW-1:0] n;

  always_comb begin
    hit_any = 1'b0; hit = '0; keep = vld;
    for (int i = 0; i < SourceSlots; i++) begin
      age = p_now - heard[i];
      if (vld[i] && id_h[i] == p_idh && id_l[i] == p_idl) begin
        hit_any = 1'b1; hit = SlotW'(i);
      end else if (vld[i] && age > {16'd0, expiry}) keep[i] = 1'b0;
    end
    d = p_seq - sq[hit];
    v_n = V_PREVIEW; we_n = 1'b0; rm_n = 1'b0; widx_n = '0;
    vld_n = vld; lvl_n = level; wr_new = 1'b0; wr_hit = 1'b0;
    free_any = 1'b0; free = '0;
    if (p_prev && ign_prev) v_n = V_PREVIEW;
    else if (p_prio > max_prio) v_n = V_BAD_PRIO;
    else if (p_sc != 8'd0 && !p_term) v_n = V_START;
    else begin
      vld_n = keep;
      if (keep == '0) lvl_n = '0;
      if (!hit_any) begin
        if (p_term || p_prio < lvl_n) v_n = V_UNTRACKED;
        else begin
          if (p_prio > lvl_n) begin
            vld_n = '0; lvl_n = p_prio;
          end
          for (int i = SourceSlots - 1; i >= 0; i--)
            if (!vld_n[i]) begin free_any = 1'b1; free = SlotW'(i); end
          if (!free_any) v_n = V_UNTRACKED;
          else begin
            vld_n[free] = 1'b1; wr_new = 1'b1;
            v_n = V_ACCEPTED; we_n = 1'b1; widx_n = free; rm_n = 1'b1;
          end
        end
      end else if (d <= 0 && d > stale_lim) v_n = V_OLD_SEQ;
      else begin
        rm_n = 1'b1; wr_hit = 1'b1;
        if (p_term) begin
          vld_n[hit] = 1'b0;
          if (vld_n == '0) lvl_n = '0;
          v_n = V_REMERGE;
        end else begin
          v_n = V_ACCEPTED; we_n = 1'b1; widx_n = hit;
          if (p_prio < lvl_n) begin
            if (popcount(vld_n) == CountW'(1)) lvl_n = p_prio;
            else begin
              vld_n[hit] = 1'b0; v_n = V_REMERGE; we_n = 1'b0; widx_n = '0;
            end
          end else if (p_prio > lvl_n) begin
            lvl_n = p_prio; vld_n = '0; vld_n[hit] = 1'b1;
          end
        end
      end
    end
    n = popcount(vld_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0; level <= '0;
    end else if (cmd.exec) begin
      vld <= vld_n; level <= lvl_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_new) begin
        id_h[free] <= p_idh; id_l[free] <= p_idl;
        sq[free] <= p_seq; heard[free] <= p_now;
      end
      if (wr_hit) begin
        sq[hit] <= p_seq;
        if (!p_term) heard[hit] <= p_now;
      end
      verdict <= v_n;
      write_enable <= we_n;
      write_index <= 3'(widx_n);
      merge_mode <= !rm_n ? M_CLEAR : (n == '0 ? M_CLEAR :
                    (n == CountW'(1) ? M_COPY : M_HTP));
      tracked_count <= 3'(n);
      current_priority <= lvl_n;
      valid_slots <= 6'(vld_n);
    end
  end
endmodule
`default_nettype wire

/* rtl/sacn_source_priority_tracker.sv */
`default_nettype none
// sACN source tracker for one universe.
// Input channel: one decoded data-packet header per word (in_valid/in_stall).
// Output channel: one verdict word per input word (out_valid/out_stall).
// Configuration: cfg_we with cfg_index and cfg_data, written while idle.
// Each word goes through capture, table update and present result, in that order.
// The next word is taken only once the result has been collected, so the
// tracker never holds more than one word at a time.
// The table update compares all six slots in parallel; that
// compare and expiry path sets the clock.
// Reset empties the source table, clears the active priority and restores
// the register defaults (preview ignored, max 200, expiry 2500 ms, limit -20).
// While out_stall is high the result holds steady and in_stall stays high.
module sacn_source_priority_tracker (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        in_valid,
  output logic              in_stall,
  input  wire  logic [63:0] source_id_high,
  input  wire  logic [63:0] source_id_low,
  input  wire  logic [7:0]  sequence_number,
  input  wire  logic [7:0]  packet_priority,
  input  wire  logic        preview_flag,
  input  wire  logic        terminate_flag,
  input  wire  logic [7:0]  slot_start_code,
  input  wire  logic [31:0] time_now_ms,
  output logic              out_valid,
  input  wire  logic        out_stall,
  output logic [2:0]        verdict,
  output logic              write_enable,
  output logic [2:0]        write_index,
  output logic [1:0]        merge_mode,
  output logic [2:0]        tracked_count,
  output logic [7:0]        current_priority,
  output logic [5:0]        valid_slots,
  input  wire  logic        cfg_we,
  input  wire  logic [1:0]  cfg_index,
  input  wire  logic [15:0] cfg_data
);
  import sspt_pkg::*;
  cmd_t cmd;

  sspt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd
  );

  sspt_datapath u_dp (
    .clk, .rst, .cmd, .cfg_we, .cfg_index, .cfg_data,
    .source_id_high, .source_id_low, .sequence_number, .packet_priority,
    .preview_flag, .terminate_flag, .slot_start_code, .time_now_ms,
    .verdict, .write_enable, .write_index, .merge_mode, .tracked_count,
    .current_priority, .valid_slots
  );
endmodule
`default_nettype wire

/* rtl/sspt_checker.sv */
`default_nettype none
module sspt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       write_enable,
  input wire logic [2:0] write_index,
  input wire logic [2:0] tracked_count,
  input wire logic [5:0] valid_slots
);
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tracked_count == 3'($countones(valid_slots)))
    else $error("count mismatch");
  a_widx: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> valid_slots[write_index])
    else $error("write slot not valid");
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result too early");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(valid_slots))
    else $error("stalled word changed");
endmodule

bind sacn_source_priority_tracker sspt_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .write_enable, .write_index, .tracked_count, .valid_slots
);
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Source tracker bench: a scoreboard model of the slot table predicts each
// verdict word; directed tests cover drops, admission, eviction and expiry,
// then random traffic, mostly from a small pool of sources, runs with idling and then without.
module tb_top;
  import sspt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [63:0] source_id_high = '0;
  logic [63:0] source_id_low = '0;
  logic [7:0] sequence_number = '0;
  logic [7:0] packet_priority = '0;
  logic preview_flag = 1'b0;
  logic terminate_flag = 1'b0;
  logic [7:0] slot_start_code = '0;
  logic [31:0] time_now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] verdict;
  logic write_enable;
  logic [2:0] write_index;
  logic [1:0] merge_mode;
  logic [2:0] tracked_count;
  logic [7:0] current_priority;
  logic [5:0] valid_slots;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sacn_source_priority_tracker dut (.*);

  typedef struct packed {
    verdict_t v;
    logic we;
    logic [2:0] idx;
    merge_t mode;
    logic [2:0] cnt;
    logic [7:0] prio;
    logic [5:0] mask;
  } verdict_word_t;

  // Shadow copy of the tracker state and registers
  logic cfg_preview;
  logic [7:0] cfg_maxprio;
  logic [15:0] cfg_expiry;
  logic signed [7:0] cfg_stale;
  logic [SourceSlots-1:0] sh_valid;
  logic [63:0] sh_idh [SourceSlots];
  logic [63:0] sh_idl [SourceSlots];
  logic [7:0] sh_seq [SourceSlots];
  logic [31:0] sh_heard [SourceSlots];
  logic [7:0] sh_level;

  verdict_word_t pending_verdicts[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  bit idle_sender = 1'b1;
  bit idle_receiver = 1'b1;
  int quiet_cycles = 0;
  logic [31:0] clock_ms = 32'd1000;

  // Pool of sender ids so that random traffic keeps hitting tracked slots
  logic [63:0] pool_h [8];
  logic [63:0] pool_l [8];
  logic [7:0] pool_seq [8];

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int live_count(input logic [SourceSlots-1:0] m);
    int n;
    n = 0;
    for (int i = 0; i < SourceSlots; i++) n += m[i];
    return n;
  endfunction

  // Work out the verdict word for one packet and advance the shadow table
  function automatic verdict_word_t track_packet(input logic [63:0] idh, input logic [63:0] idl,
      input logic [7:0] seq, input logic [7:0] prio, input logic pv, input logic tm,
      input logic [7:0] sc, input logic [31:0] now);
    verdict_word_t r;
    int hit;
    int free_slot;
    int n;
    logic remerge;
    logic signed [7:0] d;
    logic [31:0] age;
    r = '0;
    hit = -1;
    remerge = 1'b0;
    if (pv && cfg_preview) r.v = V_PREVIEW;
    else if (prio > cfg_maxprio) r.v = V_BAD_PRIO;
    else if (sc != 8'd0 && !tm) r.v = V_START;
    else begin
      for (int i = 0; i < SourceSlots; i++) begin
        if (sh_valid[i]) begin
          if (sh_idh[i] == idh && sh_idl[i] == idl) hit = i;
          else begin
            age = now - sh_heard[i];
            if (age > {16'd0, cfg_expiry}) sh_valid[i] = 1'b0;
          end
        end
      end
      if (sh_valid == '0) sh_level = '0;
      if (hit < 0) begin
        if (tm || prio < sh_level) r.v = V_UNTRACKED;
        else begin
          if (prio > sh_level) begin
            sh_valid = '0;
            sh_level = prio;
          end
          free_slot = -1;
          for (int i = SourceSlots - 1; i >= 0; i--) if (!sh_valid[i]) free_slot = i;
          if (free_slot < 0) r.v = V_UNTRACKED;
          else begin
            sh_valid[free_slot] = 1'b1;
            sh_idh[free_slot] = idh;
            sh_idl[free_slot] = idl;
            sh_seq[free_slot] = seq;
            sh_heard[free_slot] = now;
            r.v = V_ACCEPTED;
            r.we = 1'b1;
            r.idx = 3'(free_slot);
            remerge = 1'b1;
          end
        end
      end else begin
        d = seq - sh_seq[hit];
        if (d <= 0 && d > cfg_stale) r.v = V_OLD_SEQ;
        else begin
          sh_seq[hit] = seq;
          remerge = 1'b1;
          if (tm) begin
            sh_valid[hit] = 1'b0;
            if (sh_valid == '0) sh_level = '0;
            r.v = V_REMERGE;
          end else begin
            sh_heard[hit] = now;
            r.v = V_ACCEPTED;
            r.we = 1'b1;
            r.idx = 3'(hit);
            if (prio < sh_level) begin
              if (live_count(sh_valid) == 1) sh_level = prio;
              else begin
                sh_valid[hit] = 1'b0;
                r.v = V_REMERGE;
                r.we = 1'b0;
                r.idx = '0;
              end
            end else if (prio > sh_level) begin
              sh_level = prio;
              for (int i = 0; i < SourceSlots; i++) if (i != hit) sh_valid[i] = 1'b0;
            end
          end
        end
      end
    end
    n = live_count(sh_valid);
    if (remerge) r.mode = n == 0 ? M_CLEAR : (n == 1 ? M_COPY : M_HTP);
    r.cnt = 3'(n);
    r.prio = sh_level;
    r.mask = sh_valid;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch on word %0d: %s got %0d expected %0d", words_checked, what, got, want);
  endtask

  task automatic write_reg(input reg_t idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PREVIEW: cfg_preview = value[0];
      REG_MAXPRIO: cfg_maxprio = value[7:0];
      REG_EXPIRY:  cfg_expiry = value;
      default:     cfg_stale = value[7:0];
    endcase
  endtask

  // Stop sending and hold off until the table has answered every word
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Present one packet word, with an optional random gap first
  task automatic send_packet(input logic [63:0] idh, input logic [63:0] idl,
      input logic [7:0] seq, input logic [7:0] prio, input logic pv, input logic tm,
      input logic [7:0] sc, input logic [31:0] now);
    int gap;
    if (idle_sender && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    source_id_high <= idh;
    source_id_low <= idl;
    sequence_number <= seq;
    packet_priority <= prio;
    preview_flag <= pv;
    terminate_flag <= tm;
    slot_start_code <= sc;
    time_now_ms <= now;
    pending_verdicts.insert(pending_verdicts.size(),
                            track_packet(idh, idl, seq, prio, pv, tm, sc, now));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_from_pool(input int k, input logic [7:0] prio, input logic tm,
      input int step_ms);
    pool_seq[k] = pool_seq[k] + 8'd1;
    clock_ms = clock_ms + 32'(step_ms);
    send_packet(pool_h[k], pool_l[k], pool_seq[k], prio, 1'b0, tm, 8'd0, clock_ms);
  endtask

  // Compare each collected verdict word against the oldest prediction
  initial begin
    verdict_word_t want;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("unexpected verdict word", 1, 0);
        end else begin
          want = pending_verdicts.pop_front();
          if (verdict != want.v) report_mismatch("verdict", verdict, want.v);
          if (write_enable != want.we) report_mismatch("write_enable", write_enable, want.we);
          if (write_index != want.idx) report_mismatch("write_index", write_index, want.idx);
          if (merge_mode != want.mode) report_mismatch("merge_mode", merge_mode, want.mode);
          if (tracked_count != want.cnt)
            report_mismatch("tracked_count", tracked_count, want.cnt);
          if (current_priority != want.prio)
            report_mismatch("current_priority", current_priority, want.prio);
          if (valid_slots != want.mask) report_mismatch("valid_slots", valid_slots, want.mask);
        end
        words_checked++;
      end
    end
  end

  // Receiver stalls in bursts, dropped for the tail of the run
  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (idle_receiver && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: any accepted word on either side resets the count
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 5000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic test_drop_checks;
    // preview, bad priority, bad start code and untracked terminations leave the table alone
    send_packet('1, '1, 8'hFF, 8'd100, 1'b1, 1'b0, 8'd0, 32'd10);
    send_packet('0, '0, 8'd0, 8'd255, 1'b0, 1'b0, 8'd0, 32'd20);
    send_packet('0, '0, 8'd0, 8'd201, 1'b0, 1'b0, 8'd0, 32'd20);
    send_packet('0, '0, 8'd0, 8'd10, 1'b0, 1'b0, 8'hDD, 32'd30);
    send_packet('0, '0, 8'd0, 8'd10, 1'b0, 1'b1, 8'hFF, 32'd30);
    send_packet('0, '0, 8'd0, 8'd0, 1'b0, 1'b1, 8'd0, 32'd30);
  endtask

  task automatic test_admission;
    // fill every slot, overflow once, repeat and step sequences, then change priorities and terminate
    for (int k = 0; k < 7; k++) send_from_pool(k, 8'd100, 1'b0, 1);
    send_packet(pool_h[0], pool_l[0], pool_seq[0], 8'd100, 1'b0, 1'b0, 8'd0, clock_ms);
    send_packet(pool_h[1], pool_l[1], pool_seq[1] - 8'd19, 8'd100, 1'b0, 1'b0, 8'd0,
                clock_ms);
    send_packet(pool_h[2], pool_l[2], pool_seq[2] - 8'd20, 8'd100, 1'b0, 1'b0, 8'd0,
                clock_ms);
    send_from_pool(3, 8'd90, 1'b0, 1);
    send_from_pool(4, 8'd99, 1'b1, 1);
    send_from_pool(7, 8'd50, 1'b0, 1);
    send_from_pool(5, 8'd150, 1'b0, 1);
    send_from_pool(5, 8'd20, 1'b0, 1);
    send_from_pool(5, 8'd20, 1'b1, 1);
  endtask

  task automatic test_expiry;
    send_from_pool(0, 8'd0, 1'b0, 1);
    send_from_pool(1, 8'd0, 1'b0, 2600);
    send_from_pool(2, 8'd0, 1'b0, 2501);
    // wrap the millisecond clock past zero
    clock_ms = 32'hFFFF_FF00;
    send_from_pool(3, 8'd0, 1'b0, 0);
    send_from_pool(4, 8'd0, 1'b0, 512);
  endtask

  task automatic test_random_traffic(input int count);
    int k;
    int r;
    logic [7:0] prio;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 7);
      prio = 8'($urandom_range(0, 3) * 8 + 96);
      if (r < 75) begin
        if ($urandom_range(0, 9) == 0) pool_seq[k] = pool_seq[k] - 8'($urandom_range(1, 40));
        send_from_pool(k, prio, $urandom_range(0, 15) == 0, $urandom_range(0, 400));
      end else if (r < 80) begin
        send_from_pool(k, prio, 1'b0, $urandom_range(0, 65600));
      end else begin
        clock_ms = clock_ms + 32'($urandom_range(0, 50));
        send_packet({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom),
                    8'($urandom), 1'($urandom), 1'($urandom),
                    $urandom_range(0, 1) ? 8'd0 : 8'($urandom), $urandom);
      end
    end
  endtask

  task automatic test_register_settings;
    drain();
    write_reg(REG_PREVIEW, 16'd0);
    write_reg(REG_MAXPRIO, 16'd255);
    write_reg(REG_EXPIRY, 16'd1);
    write_reg(REG_STALE, 16'h0080);
    test_random_traffic(150);
    drain();
    write_reg(REG_MAXPRIO, 16'd0);
    write_reg(REG_EXPIRY, 16'hFFFF);
    write_reg(REG_STALE, 16'd0);
    test_random_traffic(100);
    drain();
    write_reg(REG_PREVIEW, 16'd1);
    write_reg(REG_MAXPRIO, 16'd120);
    write_reg(REG_EXPIRY, 16'd800);
    write_reg(REG_STALE, 16'h00F0);
  endtask

  initial begin
    cfg_preview = 1'b1;
    cfg_maxprio = 8'd200;
    cfg_expiry = 16'd2500;
    cfg_stale = -8'sd20;
    sh_valid = '0;
    sh_level = '0;
    for (int k = 0; k < 8; k++) begin
      pool_h[k] = {$urandom, $urandom};
      pool_l[k] = {$urandom, $urandom};
      pool_seq[k] = 8'($urandom);
    end
    pool_h[0] = '1;
    pool_l[0] = '1;
    pool_h[1] = '0;
    pool_l[1] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_drop_checks();
    test_admission();
    test_expiry();
    test_random_traffic(350);
    test_register_settings();
    test_random_traffic(250);
    drain();
    idle_sender = 1'b0;
    idle_receiver = 1'b0;
    test_random_traffic(150);
    drain();
    $display("covered %0d packet words across drops, admission, eviction, expiry and wrap",
             words_sent);
    $display("register extremes and several sequence limits exercised, %0d verdicts checked",
             words_checked);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/sspt_pkg.sv
rtl/sspt_ctrl.sv
rtl/sspt_datapath.sv
rtl/sacn_source_priority_tracker.sv
rtl/sspt_checker.sv
sim/tb_top.sv
